>>> rtl/core/xrng_pkg.sv
package xrng_pkg;

  typedef logic [3:0][63:0] gen_t;

  typedef struct packed {
    logic start;
    logic kill;
  } unit_ctl_t;

  localparam logic [1:0] REQ_RAW     = 2'd0;
  localparam logic [1:0] REQ_BOUNDED = 2'd1;
  localparam logic [1:0] REQ_NONZERO = 2'd2;

  localparam logic [1:0] JUMP_SHORT = 2'd1;
  localparam logic [1:0] JUMP_LONG  = 2'd2;

  localparam logic REG_SEED = 1'b0;
  localparam logic REG_JUMP = 1'b1;

  localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

  function automatic logic [63:0] jump_poly(input logic [2:0] idx);
    logic [63:0] p;
    case (idx)
      3'd0:    p = 64'h180ec6d33cfd0aba;
      3'd1:    p = 64'hd5a61266f0c9392c;
      3'd2:    p = 64'ha9582618e03fc9aa;
      3'd3:    p = 64'h39abdc4529b1661c;
      3'd4:    p = 64'h76e15d3efefdcbbf;
      3'd5:    p = 64'hc5004e441c522fb3;
      3'd6:    p = 64'h77710069854ee241;
      default: p = 64'h39109bb02acbe635;
    endcase
    return p;
  endfunction

  // rotl(s0 + s3, 23) + s0
  function automatic logic [63:0] xo_output(input gen_t s);
    logic [63:0] sum;
    sum = s[0] + s[3];
    return {sum[40:0], sum[63:41]} + s[0];
  endfunction

  function automatic gen_t xo_advance(input gen_t s);
    gen_t n;
    logic [63:0] t;
    t = s[1] << 17;
    n = s;
    n[2] = n[2] ^ n[0];
    n[3] = n[3] ^ n[1];
    n[1] = n[1] ^ n[2];
    n[0] = n[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = {n[3][18:0], n[3][63:19]};
    return n;
  endfunction

endpackage

>>> rtl/core/xoshiro256pp_bounded_rng_top.sv
// channel  | handshake            | payload
// in       | in_valid_i/in_ready_o | req_type_i, bound_i
// out      | out_valid_o/out_ready_i | value_o, bad_bound_o
// config   | psel/penable/pwrite  | paddr, pwdata, prdata (64-bit seed at 0, jump at 8)
// raw request: DRAW then DONE; nonzero request: DRAW repeats on each zero draw
// bounded request: each draw passes DRAW and the bit-serial divider in DIV, and a
// rejected draw goes back to DRAW
// seeding (reset or seed write): SplitMix steps on the shared 32x32 multiplier,
// then the jump when the jump register selects one; no item is taken meanwhile
// a result waits in the output register; items are taken meanwhile, but not in DONE
module xoshiro256pp_bounded_rng_top import xrng_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] bound_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic        bad_bound_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [7:0] {
    ST_SEED = 8'b00000001,
    ST_MUL1 = 8'b00000010,
    ST_MUL2 = 8'b00000100,
    ST_JUMP = 8'b00001000,
    ST_IDLE = 8'b00010000,
    ST_DRAW = 8'b00100000,
    ST_DIV  = 8'b01000000,
    ST_DONE = 8'b10000000
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] seed_q, ctr_q, ctr_d;
  logic [1:0]  jump_q;
  logic [1:0]  widx_q;
  logic [7:0]  jcnt_q;
  gen_t        gen_q, acc_q, acc_next, gen_adv;
  logic [1:0]  req_q;
  logic [63:0] bound_q, x_q;
  logic [63:0] res_value_q;
  logic        res_bad_q;
  logic        out_valid_q, out_bad_q;
  logic [63:0] out_value_q;

  logic        seed_wr, jump_wr, in_acc, out_load;
  logic        jump_bit;
  logic [63:0] jump_word;
  logic [63:0] draw_x, sm_z, mul_a, mul_b, mul_p, div_r, sm_word, limit, x_minus_r;
  logic        mul_done, div_done;
  unit_ctl_t   mul_ctl, div_ctl;

  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && (paddr[3] == REG_SEED);
  assign jump_wr = psel && penable && pwrite && (paddr[3] == REG_JUMP);
  assign prdata  = (paddr[3] == REG_JUMP) ? {62'd0, jump_q} : seed_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign gen_adv = xo_advance(gen_q);
  assign draw_x  = xo_output(gen_q);

  assign ctr_d   = ctr_q + SM_GAMMA;
  assign sm_z    = ctr_d ^ (ctr_d >> 30);
  assign sm_word = mul_p ^ (mul_p >> 31);

  assign jump_word = jump_poly({jump_q == JUMP_LONG, jcnt_q[7:6]});
  assign jump_bit  = jump_word[jcnt_q[5:0]];
  always_comb begin
    acc_next = acc_q;
    if (jump_bit) begin
      acc_next = acc_q ^ gen_q;
    end
  end

  assign limit     = 64'd0 - bound_q;
  assign x_minus_r = x_q - div_r;

  always_comb begin
    mul_ctl.kill  = seed_wr;
    mul_ctl.start = 1'b0;
    mul_a         = sm_z;
    mul_b         = SM_MUL1;
    if (state_q == ST_SEED) begin
      mul_ctl.start = !seed_wr;
    end else if (state_q == ST_MUL1 && mul_done) begin
      mul_ctl.start = !seed_wr;
      mul_a         = mul_p ^ (mul_p >> 27);
      mul_b         = SM_MUL2;
    end
  end

  always_comb begin
    div_ctl.kill  = seed_wr;
    div_ctl.start = (state_q == ST_DRAW) && (req_q == REQ_BOUNDED) && !seed_wr;
  end

  xrng_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  xrng_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (draw_x),
    .divisor_i  (bound_q),
    .done_o     (div_done),
    .rem_o      (div_r)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SEED: state_d = ST_MUL1;
      ST_MUL1: if (mul_done) begin
        state_d = ST_MUL2;
      end
      ST_MUL2: if (mul_done) begin
        if (widx_q != 2'd3) begin
          state_d = ST_SEED;
        end else if (jump_q == JUMP_SHORT || jump_q == JUMP_LONG) begin
          state_d = ST_JUMP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_JUMP: if (jcnt_q == 8'd255) begin
        state_d = ST_IDLE;
      end
      ST_IDLE: if (in_acc) begin
        if (req_type_i == REQ_BOUNDED && bound_i == 64'd0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (req_q == REQ_BOUNDED) begin
          state_d = ST_DIV;
        end else if (req_q == REQ_NONZERO && draw_x == 64'd0) begin
          state_d = ST_DRAW;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: if (div_done) begin
        state_d = (x_minus_r > limit) ? ST_DRAW : ST_DONE;
      end
      ST_DONE: if (out_load) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    // a seed write restarts the expansion from the new seed
    if (seed_wr) begin
      state_d = ST_SEED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED;
      seed_q      <= 64'd0;
      ctr_q       <= 64'd0;
      jump_q      <= JUMP_SHORT;
      widx_q      <= 2'd0;
      jcnt_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (jump_wr) begin
        jump_q <= pwdata[1:0];
      end
      if (seed_wr) begin
        seed_q <= pwdata;
        ctr_q  <= pwdata;
        widx_q <= 2'd0;
      end else if (state_q == ST_SEED) begin
        ctr_q <= ctr_d;
      end else if (state_q == ST_MUL2 && mul_done) begin
        widx_q <= widx_q + 2'd1;
      end
      if (state_q == ST_JUMP) begin
        jcnt_q <= jcnt_q + 8'd1;
      end else begin
        jcnt_q <= 8'd0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL2 && mul_done) begin
      gen_q[widx_q] <= sm_word;
      acc_q         <= '0;
    end else if (state_q == ST_JUMP) begin
      acc_q <= acc_next;
      if (jcnt_q == 8'd255) begin
        gen_q <= acc_next;
      end else begin
        gen_q <= gen_adv;
      end
    end else if (state_q == ST_DRAW && !seed_wr) begin
      gen_q <= gen_adv;
      x_q   <= draw_x;
      res_value_q <= draw_x;
      res_bad_q   <= 1'b0;
    end
    if (in_acc) begin
      req_q       <= req_type_i;
      bound_q     <= bound_i;
      res_value_q <= 64'd0;
      res_bad_q   <= 1'b1;
    end
    if (state_q == ST_DIV && div_done) begin
      res_value_q <= div_r;
    end
    if (out_load) begin
      out_value_q <= res_value_q;
      out_bad_q   <= res_bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign bad_bound_o = out_bad_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL1 || state_q == ST_MUL2))
    else $error("multiplier result outside seeding");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider result outside bounded draw");

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_bound_o) |-> (value_o == 64'd0))
    else $error("bad bound item with nonzero value");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("loaded result lost");
`endif

endmodule

>>> rtl/core/xrng_mul.sv
module xrng_mul import xrng_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  unit_ctl_t   ctl_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic [1:0]  step_q;
  logic        busy_q, done_q;
  logic [31:0] op_a, op_b;
  logic [63:0] part;

  // low 64 bits only: lo*lo, then the two cross terms into the upper half
  assign op_a = (step_q == 2'd1) ? a_q[63:32] : a_q[31:0];
  assign op_b = (step_q == 2'd2) ? b_q[63:32] : b_q[31:0];
  assign part = 64'(op_a) * 64'(op_b);

  always_comb begin
    if (step_q == 2'd0) begin
      acc_d = part;
    end else begin
      acc_d = acc_q + {part[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else if (ctl_i.kill) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else if (busy_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> rtl/core/xrng_div.sv
module xrng_div import xrng_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  unit_ctl_t   ctl_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] rem_o
);

  logic [63:0] rem_q, dvd_q, dsr_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] trial, diff;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, dvd_q[63]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (ctl_i.kill) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= 64'd0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      if (!diff[64]) begin
        rem_q <= diff[63:0];
      end else begin
        rem_q <= trial[63:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import xrng_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [3:0] ADDR_SEED = 4'd0;
  localparam logic [3:0] ADDR_JUMP = 4'd8;

  typedef struct packed {
    logic [63:0] value;
    logic        bad_bound;
  } draw_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = REQ_RAW;
  logic [63:0] bound_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] value_o;
  logic        bad_bound_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // model of the generator
  logic [63:0] gen_words [4];
  logic [63:0] seed_reg;
  logic [1:0]  jump_reg;

  draw_t       pending_draws[$];
  int unsigned n_cycles = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_bad_bound = 0;
  int unsigned hold_cycles = 0;
  bit          steady = 1'b0;

  xoshiro256pp_bounded_rng_top uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] rol(input logic [63:0] v, input int k);
    return (v << k) | (v >> (64 - k));
  endfunction

  function automatic logic [63:0] step_gen();
    logic [63:0] r, t;
    r = rol(gen_words[0] + gen_words[3], 23) + gen_words[0];
    t = gen_words[1] << 17;
    gen_words[2] ^= gen_words[0];
    gen_words[3] ^= gen_words[1];
    gen_words[1] ^= gen_words[2];
    gen_words[0] ^= gen_words[3];
    gen_words[2] ^= t;
    gen_words[3] = rol(gen_words[3], 45);
    return r;
  endfunction

  function automatic void jump_gen(input logic [2:0] base);
    logic [63:0] acc [4];
    logic [63:0] poly, unused;
    logic [2:0]  sel;
    for (int i = 0; i < 4; i++) acc[i] = '0;
    for (int w = 0; w < 4; w++) begin
      sel = base + 3'(w);
      case (sel)
        3'd0: poly = 64'h180ec6d33cfd0aba;
        3'd1: poly = 64'hd5a61266f0c9392c;
        3'd2: poly = 64'ha9582618e03fc9aa;
        3'd3: poly = 64'h39abdc4529b1661c;
        3'd4: poly = 64'h76e15d3efefdcbbf;
        3'd5: poly = 64'hc5004e441c522fb3;
        3'd6: poly = 64'h77710069854ee241;
        default: poly = 64'h39109bb02acbe635;
      endcase
      for (int b = 0; b < 64; b++) begin
        if (poly[b]) for (int i = 0; i < 4; i++) acc[i] ^= gen_words[i];
        unused = step_gen();
      end
    end
    for (int i = 0; i < 4; i++) gen_words[i] = acc[i];
  endfunction

  function automatic void reseed_gen();
    logic [63:0] ctr, z;
    ctr = seed_reg;
    for (int i = 0; i < 4; i++) begin
      ctr += SM_GAMMA;
      z = ctr;
      z = (z ^ (z >> 30)) * SM_MUL1;
      z = (z ^ (z >> 27)) * SM_MUL2;
      gen_words[i] = z ^ (z >> 31);
    end
    if (jump_reg == JUMP_SHORT) jump_gen(3'd0);
    else if (jump_reg == JUMP_LONG) jump_gen(3'd4);
  endfunction

  function automatic draw_t predict_draw(input logic [1:0] req, input logic [63:0] bound);
    draw_t d;
    logic [63:0] x, r, lim;
    d = '0;
    if (req == REQ_BOUNDED) begin
      if (bound == 0) begin
        d.bad_bound = 1'b1;
      end else begin
        lim = 64'd0 - bound;
        do begin
          x = step_gen();
          r = x % bound;
        end while (x - r > lim);
        d.value = r;
      end
    end else if (req == REQ_NONZERO) begin
      do d.value = step_gen(); while (d.value == 0);
    end else begin
      d.value = step_gen();
    end
    return d;
  endfunction

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               pending_draws.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 19);
    end
  end

  // outputs are stable mid-cycle; the item moves at the next rising edge
  always @(negedge clk_i) begin
    draw_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_draws.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result value=%h", value_o);
      end else begin
        want = pending_draws.pop_front();
        n_checked++;
        if (value_o !== want.value || bad_bound_o !== want.bad_bound) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result %0d: value %h bad_bound %b, expected %h %b", n_checked,
                     value_o, bad_bound_o, want.value, want.bad_bound);
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] req, input logic [63:0] bound);
    bit ready_seen;
    if (!steady && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    bound_i <= bound;
    do begin
      @(negedge clk_i);
      ready_seen = in_ready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    pending_draws.push_back(predict_draw(req, bound));
    if (req == REQ_BOUNDED && bound == 0) n_bad_bound++;
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_SEED) begin
      seed_reg = data;
      reseed_gen();
    end else begin
      jump_reg = data[1:0];
    end
  endtask

  function automatic logic [63:0] pick_bound();
    case ($urandom_range(9))
      0:       return 64'd0;
      1, 2, 3: return 64'($urandom_range(1000, 1));
      4:       return {1'b1, 31'($urandom), 32'($urandom)};
      5:       return 64'(1) << $urandom_range(63);
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [1:0] req;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2:    req = REQ_RAW;
        3, 4, 5, 6: req = REQ_BOUNDED;
        7, 8:       req = REQ_NONZERO;
        default:    req = 2'd3;
      endcase
      send_item(req, pick_bound());
    end
  endtask

  task automatic test_directed();
    send_item(REQ_RAW, 64'd0);
    send_item(REQ_RAW, '1);
    send_item(REQ_NONZERO, 64'h5555_5555_5555_5555);
    send_item(2'd3, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(REQ_BOUNDED, 64'd0);
    send_item(REQ_BOUNDED, 64'd1);
    send_item(REQ_BOUNDED, 64'd2);
    send_item(REQ_BOUNDED, 64'd3);
    send_item(REQ_BOUNDED, 64'd0);
    send_item(REQ_BOUNDED, '1);
    send_item(REQ_BOUNDED, 64'h8000_0000_0000_0000);
    send_item(REQ_BOUNDED, 64'h8000_0000_0000_0001);
    send_item(REQ_BOUNDED, 64'hffff_ffff_ffff_fffe);
    send_item(REQ_NONZERO, '1);
    send_item(REQ_RAW, 64'd7);
    wait_idle();
  endtask

  // every jump code, including the unused one, with extreme and random seeds
  task automatic test_seed_and_jump();
    write_reg(ADDR_JUMP, 64'd0);
    write_reg(ADDR_SEED, {32'($urandom), 32'($urandom)});
    send_random(200);
    wait_idle();
    write_reg(ADDR_JUMP, 64'(JUMP_LONG));
    write_reg(ADDR_SEED, 64'd0);
    send_random(200);
    wait_idle();
    write_reg(ADDR_JUMP, 64'd3);
    write_reg(ADDR_SEED, '1);
    send_random(200);
    wait_idle();
    // jump change alone must not reseed
    write_reg(ADDR_JUMP, 64'(JUMP_SHORT));
    send_random(100);
    wait_idle();
    write_reg(ADDR_SEED, {32'($urandom), 32'($urandom)});
    send_random(200);
    wait_idle();
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    send_random(150);
    hold_cycles = 600;
    send_item(REQ_RAW, 64'd0);
    repeat (20) send_item(($urandom_range(1) == 0) ? REQ_RAW : REQ_NONZERO,
                          {32'($urandom), 32'($urandom)});
    steady = 1'b0;
    send_random(150);
    // sender pauses until everything is home
    wait_idle();
    send_random(400);
    wait_idle();
  endtask

  initial begin
    seed_reg = '0;
    jump_reg = JUMP_SHORT;
    reseed_gen();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_seed_and_jump();
    test_backpressure();
    wait_idle();
    $display("%0d requests sent, %0d results compared (%0d zero bounds), over all jump modes",
             n_sent, n_checked, n_bad_bound);
    $display("mismatches: %0d, results left unchecked: %0d", n_mismatch,
             pending_draws.size());
    if (n_mismatch == 0 && pending_draws.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
